// File: sv/b64e_pkg.sv
// Package with the shared types, constants and the character map of the base64 encoder.
package b64e_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CharW   = 7;
    localparam int unsigned SextetW = 6;
    localparam int unsigned QDepth  = 2;
    localparam int unsigned QPtrW   = $clog2(QDepth);
    localparam int unsigned QCntW   = $clog2(QDepth + 1);

    localparam logic [CharW-1:0] PadChar   = 7'd61;
    localparam logic [CharW-1:0] PlusChar  = 7'd43;
    localparam logic [CharW-1:0] SlashChar = 7'd47;

    typedef enum logic [1:0] {
        CHAR_FIRST  = 2'd0,
        CHAR_SECOND = 2'd1,
        CHAR_THIRD  = 2'd2,
        CHAR_FOURTH = 2'd3
    } char_pos_t;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_ONE  = 2'd1,
        HELD_TWO  = 2'd2,
        HELD_BAD  = 2'd3
    } held_cnt_t;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [CharW-1:0] char_out;
        logic             last;
    } char_item_t;

    typedef struct packed {
        logic [ByteW-1:0] b0;
        logic [ByteW-1:0] b1;
        logic [ByteW-1:0] b2;
        logic             has_b1;
        logic             has_b2;
        logic             eom;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [CharW-1:0] b64_char(input logic [SextetW-1:0] v);
        logic [CharW-1:0] res;
        logic [CharW-1:0] vx;
        vx = {1'b0, v};
        if (v < 6'd26)
        begin
            res = 7'd65 + vx;
        end
        else if (v < 6'd52)
        begin
            res = 7'd71 + vx;
        end
        else if (v < 6'd62)
        begin
            res = vx - 7'd4;
        end
        else if (v == 6'd62)
        begin
            res = PlusChar;
        end
        else
        begin
            res = SlashChar;
        end
        return res;
    endfunction

endpackage

// File: sv/b64e_front.sv
// Front part: accepts source bytes, holds partial groups and hands finished groups to the queue.
module b64e_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  b64e_pkg::byte_item_t byte_item,
    input  b64e_pkg::q_status_t q_status,
    output logic                push,
    output b64e_pkg::group_t    push_group
);
    import b64e_pkg::*;

    logic [ByteW-1:0] held0_reg, held0_next;
    logic [ByteW-1:0] held1_reg, held1_next;
    held_cnt_t        count_reg, count_next;
    held_cnt_t        count_eff;
    logic             take;

    assign byte_stall = q_status.full;
    assign take       = byte_valid && !q_status.full;
    assign count_eff  = (count_reg == HELD_BAD) ? HELD_NONE : count_reg;

    always_comb
    begin
        push_group = '0;
        push       = 1'b0;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        unique case (count_eff)
            HELD_NONE:
            begin
                push_group.b0 = byte_item.data_byte;
            end
            HELD_ONE:
            begin
                push_group.b0     = held0_reg;
                push_group.b1     = byte_item.data_byte;
                push_group.has_b1 = 1'b1;
            end
            default:
            begin
                push_group.b0     = held0_reg;
                push_group.b1     = held1_reg;
                push_group.b2     = byte_item.data_byte;
                push_group.has_b1 = 1'b1;
                push_group.has_b2 = 1'b1;
            end
        endcase
        push_group.eom = byte_item.end_of_message;
        if (take)
        begin
            if (byte_item.end_of_message || count_eff == HELD_TWO)
            begin
                push       = 1'b1;
                count_next = HELD_NONE;
            end
            else if (count_eff == HELD_NONE)
            begin
                held0_next = byte_item.data_byte;
                count_next = HELD_ONE;
            end
            else
            begin
                held1_next = byte_item.data_byte;
                count_next = HELD_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= HELD_NONE;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

endmodule

// File: sv/b64e_queue.sv
// Short group queue between the front and back parts.
module b64e_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64e_pkg::group_t    push_group,
    input  logic                pop,
    output b64e_pkg::group_t    head_group,
    output b64e_pkg::q_status_t q_status
);
    import b64e_pkg::*;

    group_t           entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QCntW'(QDepth));
    assign q_status.empty = (count_reg == '0);
    assign head_group     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QDepth))
        else $error("Queue fill count out of range.");

endmodule

// File: sv/b64e_back.sv
// Back part: turns one queued group into four characters on the output register.
module b64e_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64e_pkg::group_t     head_group,
    input  b64e_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 char_valid,
    input  logic                 char_stall,
    output b64e_pkg::char_item_t char_item
);
    import b64e_pkg::*;

    char_pos_t        pos_reg, pos_next;
    logic             valid_reg, valid_next;
    char_item_t       out_reg, out_next;
    logic             advance;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [SextetW-1:0] sx;
    logic             pad;

    assign advance    = !valid_reg || !char_stall;
    assign char_valid = valid_reg;
    assign char_item  = out_reg;
    assign b1         = head_group.has_b1 ? head_group.b1 : '0;
    assign b2         = head_group.has_b2 ? head_group.b2 : '0;

    always_comb
    begin
        pad = 1'b0;
        unique case (pos_reg)
            CHAR_FIRST:  sx = head_group.b0[7:2];
            CHAR_SECOND: sx = {head_group.b0[1:0], b1[7:4]};
            CHAR_THIRD:
            begin
                sx  = {b1[3:0], b2[7:6]};
                pad = !head_group.has_b1;
            end
            default:
            begin
                sx  = b2[5:0];
                pad = !head_group.has_b2;
            end
        endcase
        pos_next   = pos_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        if (advance)
        begin
            valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                out_next.char_out = pad ? PadChar : b64_char(sx);
                out_next.last     = (pos_reg == CHAR_FOURTH) && head_group.eom;
                pos_next          = char_pos_t'(pos_reg + 2'd1);
                pop               = (pos_reg == CHAR_FOURTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= CHAR_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_reg.last) |-> (pos_reg == CHAR_FIRST))
        else $error("Last flag shown in the middle of a group.");

    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != CHAR_FIRST) |-> !q_status.empty)
        else $error("Group left the queue before all characters were sent.");

    a_pad_position: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_reg.char_out == PadChar)
            |-> (pos_reg == CHAR_FOURTH || pos_reg == CHAR_FIRST))
        else $error("Pad character outside the tail of a group.");

endmodule

// File: sv/base64_encoder_core.sv
// Top level of the streaming base64 encoder with padding.
// A byte that closes a group is written into the group queue; its first character then goes to the output register.
// Throughput: one character per cycle from the back part while a group is queued and the output is not stalled.
// The input takes one byte per cycle until the two-entry group queue is full.
// Reset is asynchronous and active low; it empties the held group, the queue and the output.
module base64_encoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  b64e_pkg::byte_item_t byte_item,
    output logic                 char_valid,
    input  logic                 char_stall,
    output b64e_pkg::char_item_t char_item
);
    import b64e_pkg::*;

    q_status_t q_status;
    group_t    push_group;
    group_t    head_group;
    logic      push;
    logic      pop;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_group (head_group),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the streaming base64 encoder core.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int unsigned IdleLimit   = 2000;
    localparam int unsigned RandomBytes = 450;
    localparam int unsigned LongHold    = 90;
    localparam int unsigned ReportCap   = 250;
    localparam logic [31:0] NoText      = 32'd0;

    typedef struct packed {
        byte_item_t  item;
        logic [31:0] text;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       char_valid;
    logic       char_stall;
    char_item_t char_item;

    logic [ByteW-1:0] held_byte [2];
    held_cnt_t        held_cnt;
    char_item_t       pending_chars [$];
    char_item_t       next_char;
    dir_row_t         dir_rows [$];
    int unsigned      mismatches = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      chars_seen = 0;

    base64_encoder_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always #6 clk = ~clk;

    function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = "A" + v;
        end
        else if (v < 6'd52)
        begin
            c = "a" + (v - 6'd26);
        end
        else if (v < 6'd62)
        begin
            c = "0" + (v - 6'd52);
        end
        else if (v == 6'd62)
        begin
            c = {1'b0, PlusChar};
        end
        else
        begin
            c = {1'b0, SlashChar};
        end
        return c[CharW-1:0];
    endfunction

    function automatic int encode_byte(input byte_item_t it, output char_item_t chars [4]);
        logic [ByteW-1:0] g0;
        logic [ByteW-1:0] g1;
        logic [ByteW-1:0] g2;
        int               cnt;
        cnt = (held_cnt == HELD_BAD) ? 0 : int'(held_cnt);
        g0 = held_byte[0];
        g1 = held_byte[1];
        g2 = '0;
        case (cnt)
            0: g0 = it.data_byte;
            1: g1 = it.data_byte;
            default: g2 = it.data_byte;
        endcase
        cnt = cnt + 1;
        if (cnt < 3 && !it.end_of_message)
        begin
            held_byte[0] = g0;
            held_byte[1] = g1;
            held_cnt = held_cnt_t'(cnt);
            return 0;
        end
        if (cnt < 2)
        begin
            g1 = '0;
        end
        chars[0] = '{char_out: sextet_char(g0[7:2]), last: 1'b0};
        chars[1] = '{char_out: sextet_char({g0[1:0], g1[7:4]}), last: 1'b0};
        chars[2] = '{char_out: (cnt >= 2) ? sextet_char({g1[3:0], g2[7:6]}) : PadChar,
                     last: 1'b0};
        chars[3] = '{char_out: (cnt == 3) ? sextet_char(g2[5:0]) : PadChar,
                     last: it.end_of_message};
        held_byte[0] = '0;
        held_byte[1] = '0;
        held_cnt = HELD_NONE;
        return 4;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic eom, input logic [31:0] text);
        dir_row_t row;
        row.item.data_byte = b;
        row.item.end_of_message = eom;
        row.text = text;
        dir_rows.push_back(row);
    endtask

    task automatic send_byte(input byte_item_t it, input int unsigned gap,
                             input logic [31:0] text);
        char_item_t chars [4];
        int         n;
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_item <= it;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        n = encode_byte(it, chars);
        if (text != NoText)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pending_chars.push_back('{char_out: text[30-8*k -: 7],
                                          last: (k == 3) ? it.end_of_message : 1'b0});
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                pending_chars.push_back(chars[k]);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (char_valid && !char_stall)
            begin
                chars_seen <= chars_seen + 1;
                if (pending_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= ReportCap)
                    begin
                        $display("%0t: expected no transaction, got char %0d last %0b",
                                 $time, char_item.char_out, char_item.last);
                    end
                end
                else
                begin
                    next_char = pending_chars.pop_front();
                    if (char_item !== next_char)
                    begin
                        mismatches++;
                        if (mismatches <= ReportCap)
                        begin
                            $display("%0t: expected char %0d last %0b, got char %0d last %0b",
                                     $time, next_char.char_out, next_char.last,
                                     char_item.char_out, char_item.last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned hold;
        bit          long_hold_done;
        bit          rx_lazy;
        long_hold_done = 1'b0;
        rx_lazy = 1'b1;
        char_stall = 1'b0;
        while (!rst_n)
        begin
            @(negedge clk);
        end
        forever
        begin
            if (chars_seen % 40 == 0)
            begin
                rx_lazy = ($urandom_range(0, 2) != 0);
            end
            if (!long_hold_done && chars_seen >= 120)
            begin
                hold = LongHold;
                long_hold_done = 1'b1;
            end
            else
            begin
                hold = rx_lazy ? $urandom_range(0, 11) : 0;
            end
            if (hold > 0)
            begin
                @(negedge clk);
                char_stall <= 1'b1;
                repeat (hold - 1)
                begin
                    @(negedge clk);
                end
            end
            @(negedge clk);
            char_stall <= 1'b0;
            @(posedge clk);
            while (!char_valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        byte_item_t  it;
        int unsigned rand_sent;
        int unsigned len;
        bit          eager;
        bit          paused;
        clk = 1'b0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        held_byte[0] = '0;
        held_byte[1] = '0;
        held_cnt = HELD_NONE;
        rand_sent = 0;
        paused = 1'b0;

        add_row(8'h00, 1'b1, "AA==");
        add_row(8'hFF, 1'b1, "/w==");
        add_row(8'hFF, 1'b0, NoText);
        add_row(8'hFF, 1'b1, "//8=");
        add_row(8'hFF, 1'b0, NoText);
        add_row(8'hFF, 1'b0, NoText);
        add_row(8'hFF, 1'b1, "////");
        add_row(8'h00, 1'b0, NoText);
        add_row(8'h00, 1'b0, NoText);
        add_row(8'h00, 1'b1, "AAAA");
        add_row(8'hFB, 1'b0, NoText);
        add_row(8'hEF, 1'b0, NoText);
        add_row(8'hBE, 1'b0, "++++");
        add_row(8'h10, 1'b1, "EA==");
        add_row(8'h4D, 1'b0, NoText);
        add_row(8'h61, 1'b0, NoText);
        add_row(8'h6E, 1'b1, "TWFu");
        add_row(8'h4D, 1'b0, NoText);
        add_row(8'h61, 1'b1, "TWE=");
        add_row(8'h80, 1'b0, NoText);
        add_row(8'h01, 1'b0, NoText);
        add_row(8'h7F, 1'b0, NoText);
        add_row(8'h55, 1'b1, NoText);

        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].item, $urandom_range(0, 11), dir_rows[i].text);
        end

        while (rand_sent < RandomBytes)
        begin
            if (!paused && rand_sent >= RandomBytes / 2)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            eager = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++)
            begin
                it.data_byte = 8'($urandom_range(0, 255));
                it.end_of_message = (k == len - 1);
                send_byte(it, eager ? 0 : $urandom_range(0, 11), NoText);
            end
            rand_sent += len;
        end
        @(negedge clk);
        byte_valid <= 1'b0;

        wait_drained();
        repeat (8)
        begin
            @(posedge clk);
        end
        if (mismatches == 0 && pending_chars.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
